### hdl/tfdb_pkg.sv
// ----------------------------------------------------------------------------
// tfdb_pkg
// Shared types and constants for the timestamped frame delay buffer.
// ----------------------------------------------------------------------------
package tfdb_pkg;

    localparam int unsigned TIME_W   = 48;
    localparam int unsigned BYTES_W  = 32;
    localparam int unsigned MBYTES_W = 13;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned TOTAL_W  = 35;
    localparam int unsigned LIMIT_W  = 33;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned SLOT_W   = 8;
    localparam int unsigned DIFF_W   = 50;
    localparam int unsigned BEST_W   = 10;

    localparam int unsigned MBYTE_SHIFT = 20;
    localparam logic [BEST_W-1:0] START_DIFF = 10'd1000;
    localparam logic [MBYTES_W-1:0] MBYTES_RESET = 13'd128;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_MBYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MS      = 1'd1;

    typedef struct packed {
        logic load;
        logic rd_oldest;
        logic drop;
        logic append;
        logic scan_issue;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic op_query;
        logic bytes_zero;
        logic full;
        logic empty;
        logic over_limit;
        logic scan_more;
        logic scan_done;
        logic send;
        logic out_free;
    } t_dp_status;

endpackage

### hdl/tfdb_ctrl.sv
// ----------------------------------------------------------------------------
// tfdb_ctrl
// Sequencer for push, eviction and query scan of the frame delay buffer.
// ----------------------------------------------------------------------------
module tfdb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tfdb_pkg::t_dp_status  i_status,
    output tfdb_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FULL_RD,
        S_FULL_SUB,
        S_APPEND,
        S_CHECK,
        S_DROP_RD,
        S_DROP_SUB,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op_query) begin
                    n_state = i_status.empty ? S_IDLE : S_SCAN;
                end else if (i_status.bytes_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.full) begin
                    n_state = S_FULL_RD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_FULL_RD: begin
                o_cmd.rd_oldest = 1'b1;
                n_state = S_FULL_SUB;
            end
            S_FULL_SUB: begin
                o_cmd.drop = 1'b1;
                n_state = S_APPEND;
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_status.over_limit ? S_DROP_RD : S_IDLE;
            end
            S_DROP_RD: begin
                o_cmd.rd_oldest = 1'b1;
                n_state = S_DROP_SUB;
            end
            S_DROP_SUB: begin
                o_cmd.drop = 1'b1;
                n_state = S_CHECK;
            end
            S_SCAN: begin
                o_cmd.scan_issue = i_status.scan_more;
                if (i_status.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_status.send) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hdl/tfdb_dp.sv
// ----------------------------------------------------------------------------
// tfdb_dp
// Descriptor ring, byte accounting, closest-stamp scan and output register.
// ----------------------------------------------------------------------------
module tfdb_dp #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tfdb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tfdb_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_op,
    input  logic [tfdb_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [tfdb_pkg::BYTES_W-1:0]         i_frame_bytes,
    input  tfdb_pkg::t_dp_cmd                    i_cmd,
    output tfdb_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tfdb_pkg::SLOT_W-1:0]          o_slot,
    output logic [tfdb_pkg::TIME_W-1:0]          o_frame_time,
    output logic [tfdb_pkg::BYTES_W-1:0]         o_frame_len
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);

    // configuration
    logic [tfdb_pkg::MBYTES_W-1:0] r_mbytes;
    logic [tfdb_pkg::DELAY_W-1:0]  r_delay;

    // ring
    logic [tfdb_pkg::TIME_W-1:0]  r_stamp_mem [DEPTH];
    logic [tfdb_pkg::BYTES_W-1:0] r_size_mem  [DEPTH];
    logic [tfdb_pkg::TIME_W-1:0]  r_rd_stamp;
    logic [tfdb_pkg::BYTES_W-1:0] r_rd_size;
    logic [AW-1:0]                r_oldest;
    logic [CW-1:0]                r_count;
    logic [tfdb_pkg::TOTAL_W-1:0] r_total;

    // latched item
    logic                         r_op;
    logic [tfdb_pkg::TIME_W-1:0]  r_time;
    logic [tfdb_pkg::BYTES_W-1:0] r_bytes;

    // scan
    logic signed [tfdb_pkg::DIFF_W-1:0] r_target;
    logic [AW-1:0]                r_scan_ptr;
    logic [CW-1:0]                r_left;
    logic                         r_eval_v;
    logic [AW-1:0]                r_eval_slot;
    logic [tfdb_pkg::BEST_W-1:0]  r_best;
    logic                         r_closer;
    logic                         r_stop;
    logic                         r_first;
    logic [AW-1:0]                r_pick;
    logic [tfdb_pkg::TIME_W-1:0]  r_pick_stamp;
    logic [tfdb_pkg::BYTES_W-1:0] r_pick_len;

    // forwarding
    logic                         r_last_valid;
    logic [tfdb_pkg::TIME_W-1:0]  r_last_time;
    logic                         r_out_valid;
    logic [tfdb_pkg::SLOT_W-1:0]  r_out_slot;
    logic [tfdb_pkg::TIME_W-1:0]  r_out_time;
    logic [tfdb_pkg::BYTES_W-1:0] r_out_len;

    logic [AW-1:0]                w_rd_addr;
    logic [AW:0]                  w_tail_sum;
    logic [AW-1:0]                w_tail;
    logic [tfdb_pkg::LIMIT_W-1:0] w_limit;
    logic signed [tfdb_pkg::DIFF_W-1:0] w_diff;
    logic [tfdb_pkg::DIFF_W-1:0]  w_abs;
    logic                         w_lt;
    logic                         w_gt;
    logic                         w_eval;
    logic [AW+7:0]                w_slot_ext;

    assign w_rd_addr  = i_cmd.scan_issue ? r_scan_ptr : r_oldest;
    assign w_tail_sum = {1'b0, r_oldest} + (AW + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= DEPTH_EXT) ? AW'(w_tail_sum - DEPTH_EXT)
                                                  : w_tail_sum[AW-1:0];
    assign w_limit    = {r_mbytes, {tfdb_pkg::MBYTE_SHIFT{1'b0}}};

    assign w_diff = $signed({2'b00, r_rd_stamp}) - r_target;
    assign w_abs  = w_diff[tfdb_pkg::DIFF_W-1] ? $unsigned(-w_diff) : $unsigned(w_diff);
    assign w_lt   = w_abs < tfdb_pkg::DIFF_W'(r_best);
    assign w_gt   = w_abs > tfdb_pkg::DIFF_W'(r_best);
    assign w_eval = r_eval_v && !r_stop;

    assign w_slot_ext = {8'd0, r_pick};

    always_comb begin
        o_status            = '0;
        o_status.op_query   = (r_op == tfdb_pkg::OP_QUERY);
        o_status.bytes_zero = (r_bytes == '0);
        o_status.full       = (r_count == FULL_CNT);
        o_status.empty      = (r_count == '0);
        o_status.over_limit = (r_total > tfdb_pkg::TOTAL_W'(w_limit)) && (r_count != '0);
        o_status.scan_more  = !r_stop && (r_left != '0);
        o_status.scan_done  = (r_stop || (r_left == '0)) && !r_eval_v;
        o_status.send       = !(r_last_valid && (r_pick_stamp == r_last_time));
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbytes <= tfdb_pkg::MBYTES_RESET;
            r_delay  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfdb_pkg::CFG_BUFFER_MBYTES: r_mbytes <= i_cfg_data[tfdb_pkg::MBYTES_W-1:0];
                tfdb_pkg::CFG_DELAY_MS:      r_delay  <= i_cfg_data[tfdb_pkg::DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // descriptor memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_stamp_mem[w_tail] <= r_time;
            r_size_mem[w_tail]  <= r_bytes;
        end
        if (i_cmd.rd_oldest || i_cmd.scan_issue) begin
            r_rd_stamp <= r_stamp_mem[w_rd_addr];
            r_rd_size  <= r_size_mem[w_rd_addr];
        end
    end

    // ring pointers and byte total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            r_total  <= '0;
        end else if (i_cmd.drop) begin
            r_oldest <= (r_oldest == LAST_SLOT) ? '0 : r_oldest + 1'b1;
            r_count  <= r_count - 1'b1;
            r_total  <= r_total - tfdb_pkg::TOTAL_W'(r_rd_size);
        end else if (i_cmd.append) begin
            r_count  <= r_count + 1'b1;
            r_total  <= r_total + tfdb_pkg::TOTAL_W'(r_bytes);
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_time   <= i_time_ms;
            r_bytes  <= i_frame_bytes;
            r_target <= $signed({2'b00, i_time_ms}) - $signed(tfdb_pkg::DIFF_W'(r_delay));
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_v <= 1'b0;
            r_left   <= '0;
            r_stop   <= 1'b0;
            r_closer <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_eval_v <= i_cmd.scan_issue;
            if (i_cmd.load) begin
                r_left   <= r_count;
                r_stop   <= 1'b0;
                r_closer <= 1'b0;
                r_first  <= 1'b1;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_left <= r_left - 1'b1;
                end
                if (w_eval) begin
                    r_first <= 1'b0;
                    if (w_lt) begin
                        r_closer <= 1'b1;
                    end else if (r_closer && w_gt) begin
                        r_stop <= 1'b1;
                    end
                end
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scan_ptr <= r_oldest;
            r_best     <= tfdb_pkg::START_DIFF;
        end else begin
            if (i_cmd.scan_issue) begin
                r_scan_ptr <= (r_scan_ptr == LAST_SLOT) ? '0 : r_scan_ptr + 1'b1;
            end
            if (w_eval && w_lt) begin
                r_best <= w_abs[tfdb_pkg::BEST_W-1:0];
            end
        end
        if (i_cmd.scan_issue) begin
            r_eval_slot <= r_scan_ptr;
        end
        if (w_eval && (w_lt || r_first)) begin
            r_pick       <= r_eval_slot;
            r_pick_stamp <= r_rd_stamp;
            r_pick_len   <= r_rd_size;
        end
    end

    // forwarding and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (i_cmd.emit) begin
            r_last_valid <= 1'b1;
            r_out_valid  <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_last_time <= r_pick_stamp;
            r_out_slot  <= w_slot_ext[7:0];
            r_out_time  <= r_pick_stamp;
            r_out_len   <= r_pick_len;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_out_slot;
    assign o_frame_time = r_out_time;
    assign o_frame_len  = r_out_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond ring depth");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("byte total nonzero with empty ring");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_last_valid && (r_last_time == o_frame_time)))
        else $error("last forwarded stamp not tracked");

    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop |-> (r_count != '0))
        else $error("drop from empty ring");

endmodule

### hdl/timestamped_frame_delay_buffer.sv
// ----------------------------------------------------------------------------
// timestamped_frame_delay_buffer
// Ring of frame descriptors with byte-limit eviction and delayed lookup.
// ----------------------------------------------------------------------------
// Push: decode, append, limit check; a full ring first evicts its oldest entry, and
//   oldest entries are evicted while over the byte limit; zero-size pushes skip all.
// Query: scans from the oldest entry (up to DEPTH) on the one read port of the
//   descriptor memory, none if the ring is empty. One beat in flight at a time.
// A forwarded result, valid as ready returns, waits on an unaccepted output beat.
// Synchronous active-low reset presets config, clears pointers, totals, not memories.
module timestamped_frame_delay_buffer #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tfdb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tfdb_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_op,
    input  logic [tfdb_pkg::TIME_W-1:0]          i_time_ms,
    input  logic [tfdb_pkg::BYTES_W-1:0]         i_frame_bytes,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tfdb_pkg::SLOT_W-1:0]          o_slot,
    output logic [tfdb_pkg::TIME_W-1:0]          o_frame_time,
    output logic [tfdb_pkg::BYTES_W-1:0]         o_frame_len
);

    tfdb_pkg::t_dp_cmd    w_cmd;
    tfdb_pkg::t_dp_status w_status;

    tfdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tfdb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_op),
        .i_time_ms     (i_time_ms),
        .i_frame_bytes (i_frame_bytes),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot        (o_slot),
        .o_frame_time  (o_frame_time),
        .o_frame_len   (o_frame_len)
    );

endmodule

### sim/timestamped_frame_delay_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_frame_delay_buffer_tb
// Drives push and query beats into the frame delay buffer under random
// sender gaps and receiver stalls, predicts every forwarded frame from a
// local copy of the descriptor ring, and checks each output beat in order.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [tfdb_pkg::SLOT_W-1:0]  slot;
    logic [tfdb_pkg::TIME_W-1:0]  frame_time;
    logic [tfdb_pkg::BYTES_W-1:0] frame_len;
} t_fwd_frame;

class frame_ring_scoreboard;
    localparam int unsigned RING_DEPTH = 256;

    logic [tfdb_pkg::TIME_W-1:0]   stamp_mem [RING_DEPTH];
    logic [tfdb_pkg::BYTES_W-1:0]  size_mem  [RING_DEPTH];
    int unsigned                   oldest;
    int unsigned                   fill;
    longint unsigned               held_bytes;
    logic [tfdb_pkg::TIME_W-1:0]   last_time;
    bit                            last_valid;
    logic [tfdb_pkg::MBYTES_W-1:0] limit_mb;
    logic [tfdb_pkg::DELAY_W-1:0]  delay_cfg;
    t_fwd_frame                    frames_due [$];
    int unsigned                   errors;

    function new();
        oldest     = 0;
        fill       = 0;
        held_bytes = 0;
        last_time  = '0;
        last_valid = 1'b0;
        limit_mb   = tfdb_pkg::MBYTES_RESET;
        delay_cfg  = '0;
        errors     = 0;
    endfunction

    function void set_config(logic [tfdb_pkg::MBYTES_W-1:0] mb,
                             logic [tfdb_pkg::DELAY_W-1:0] dl);
        limit_mb  = mb;
        delay_cfg = dl;
    endfunction

    function int unsigned waiting();
        return frames_due.size();
    endfunction

    function void drop_oldest();
        if (fill == 0) return;
        held_bytes -= size_mem[oldest];
        oldest = (oldest + 1) % RING_DEPTH;
        fill--;
    endfunction

    // Accepted input beat: update the ring and queue the frame it forwards.
    function void take_request(logic op, logic [tfdb_pkg::TIME_W-1:0] t,
                               logic [tfdb_pkg::BYTES_W-1:0] nbytes);
        longint unsigned limit;
        longint          target;
        longint          diff;
        longint          best;
        int unsigned     idx;
        int unsigned     s;
        int unsigned     pick;
        bit              closer;
        t_fwd_frame      f;
        if (op == tfdb_pkg::OP_PUSH) begin
            if (nbytes == '0) return;
            if (fill >= RING_DEPTH) drop_oldest();
            s = (oldest + fill) % RING_DEPTH;
            stamp_mem[s] = t;
            size_mem[s]  = nbytes;
            fill++;
            held_bytes += nbytes;
            limit = longint'(limit_mb) << tfdb_pkg::MBYTE_SHIFT;
            while (held_bytes > limit && fill > 0) drop_oldest();
            return;
        end
        if (fill == 0) return;
        target = $signed({16'd0, t}) - $signed({48'd0, delay_cfg});
        best   = tfdb_pkg::START_DIFF;
        closer = 1'b0;
        pick   = oldest;
        for (idx = 0; idx < fill; idx++) begin
            s    = (oldest + idx) % RING_DEPTH;
            diff = $signed({16'd0, stamp_mem[s]}) - target;
            if (diff < 0) diff = -diff;
            if (diff < best) begin
                best   = diff;
                pick   = s;
                closer = 1'b1;
            end else if (closer && diff > best) begin
                break;
            end
        end
        if (last_valid && stamp_mem[pick] == last_time) return;
        last_time    = stamp_mem[pick];
        last_valid   = 1'b1;
        f.slot       = tfdb_pkg::SLOT_W'(pick);
        f.frame_time = stamp_mem[pick];
        f.frame_len  = size_mem[pick];
        frames_due   = {frames_due, f};
    endfunction

    function void flag(string what, longint unsigned want, longint unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endfunction

    function void check_forward(logic [tfdb_pkg::SLOT_W-1:0] slot,
                                logic [tfdb_pkg::TIME_W-1:0] t,
                                logic [tfdb_pkg::BYTES_W-1:0] len);
        t_fwd_frame want;
        if (frames_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual slot %0d time 0x%0h len 0x%0h",
                     $time, slot, t, len);
            return;
        end
        want = frames_due[0];
        frames_due.delete(0);
        if (slot !== want.slot) flag("slot", want.slot, slot);
        if (t !== want.frame_time) flag("frame_time", want.frame_time, t);
        if (len !== want.frame_len) flag("frame_len", want.frame_len, len);
    endfunction
endclass

module timestamped_frame_delay_buffer_tb;

    localparam int unsigned SETTLE_CYCLES = 600;
    localparam int unsigned DRAIN_GUARD   = 20000;
    localparam int unsigned LONG_HOLD     = 3000;
    localparam int unsigned SIZE_SMALL    = 0;
    localparam int unsigned SIZE_MEDIUM   = 1;
    localparam int unsigned SIZE_HUGE     = 2;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tfdb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tfdb_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           in_op = tfdb_pkg::OP_PUSH;
    logic [tfdb_pkg::TIME_W-1:0]    in_time = '0;
    logic [tfdb_pkg::BYTES_W-1:0]   in_bytes = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [tfdb_pkg::SLOT_W-1:0]    out_slot;
    logic [tfdb_pkg::TIME_W-1:0]    out_time;
    logic [tfdb_pkg::BYTES_W-1:0]   out_len;

    frame_ring_scoreboard          sb;
    longint                        clock_ms = 0;
    int unsigned                   burst_left = 0;
    logic [tfdb_pkg::DELAY_W-1:0]  cur_delay = '0;
    bit                            rx_hold_req = 1'b0;

    timestamped_frame_delay_buffer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_op          (in_op),
        .i_time_ms     (in_time),
        .i_frame_bytes (in_bytes),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_slot        (out_slot),
        .o_frame_time  (out_time),
        .o_frame_len   (out_len)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.take_request(in_op, in_time, in_bytes);
            if (out_valid && out_ready) sb.check_forward(out_slot, out_time, out_len);
        end
    end

    // Receiver: ready pattern in modes, plus a long hold-off on request.
    initial begin : rx_pattern
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #(64'd50_000_000);
        $display("%0t: timeout", $time);
        $display("timestamped_frame_delay_buffer_tb failed");
        $finish;
    end

    task automatic drive_beat(input logic op, input logic [tfdb_pkg::TIME_W-1:0] t,
                              input logic [tfdb_pkg::BYTES_W-1:0] nbytes);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_op    <= op;
        in_time  <= t;
        in_bytes <= nbytes;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Sender stops until every frame due has arrived or a guard expires, then lets pushes finish.
    task automatic drain_and_settle();
        int unsigned guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting() != 0 && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_config(input logic [tfdb_pkg::MBYTES_W-1:0] mb,
                                input logic [tfdb_pkg::DELAY_W-1:0] dl);
        cfg_we    <= 1'b1;
        cfg_index <= tfdb_pkg::CFG_BUFFER_MBYTES;
        cfg_data  <= tfdb_pkg::CFG_W'(mb);
        @(posedge clk);
        cfg_index <= tfdb_pkg::CFG_DELAY_MS;
        cfg_data  <= dl;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_config(mb, dl);
        cur_delay = dl;
    endtask

    function automatic logic [tfdb_pkg::BYTES_W-1:0] frame_size(input int unsigned size_kind);
        if ($urandom_range(0, 29) == 0) return '0;
        case (size_kind)
            SIZE_SMALL:  return tfdb_pkg::BYTES_W'($urandom_range(1, 4096));
            SIZE_MEDIUM: return tfdb_pkg::BYTES_W'($urandom_range(1, 1 << 24));
            default:     return tfdb_pkg::BYTES_W'($urandom);
        endcase
    endfunction

    // Well-formed traffic: pushes on an advancing clock, queries aimed near it.
    task automatic run_stream(input int unsigned n_items, input int unsigned size_kind,
                              input int unsigned push_pct);
        int unsigned k;
        longint      target;
        longint      now;
        longint      prev_now;
        bit          have_prev;
        have_prev = 1'b0;
        prev_now  = 0;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < push_pct) begin
                clock_ms += $urandom_range(0, 40);
                drive_beat(tfdb_pkg::OP_PUSH, tfdb_pkg::TIME_W'(clock_ms),
                           frame_size(size_kind));
            end else begin
                if (have_prev && $urandom_range(0, 7) == 0) begin
                    now = prev_now;
                end else begin
                    target = clock_ms - longint'($urandom_range(0, 1500));
                    now    = target + longint'(cur_delay);
                    if (now < 0) now = $urandom_range(0, 500);
                end
                drive_beat(tfdb_pkg::OP_QUERY, tfdb_pkg::TIME_W'(now),
                           tfdb_pkg::BYTES_W'($urandom));
                prev_now  = now;
                have_prev = 1'b1;
            end
        end
    endtask

    task automatic run_noise(input int unsigned n_items);
        int unsigned k;
        for (k = 0; k < n_items; k++) begin
            drive_beat(($urandom_range(0, 1) == 1) ? tfdb_pkg::OP_QUERY : tfdb_pkg::OP_PUSH,
                       tfdb_pkg::TIME_W'({$urandom, $urandom}),
                       ($urandom_range(0, 4) == 0) ? '0 : tfdb_pkg::BYTES_W'($urandom));
        end
    endtask

    task automatic run_phase(input logic [tfdb_pkg::MBYTES_W-1:0] mb,
                             input logic [tfdb_pkg::DELAY_W-1:0] dl,
                             input int unsigned n_items, input bit with_fill,
                             input bit with_hold);
        int unsigned done;
        int unsigned len;
        int unsigned sel;
        int unsigned size_kind;
        drain_and_settle();
        write_config(mb, dl);
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
            clock_ms = $urandom_range(0, 3000);
        end else if (sel == 1) begin
            clock_ms = (longint'($urandom_range(0, 32767)) << 32) | longint'($urandom);
        end else begin
            clock_ms = (longint'(1) << tfdb_pkg::TIME_W) - 400000;
        end
        done = 0;
        if (with_fill) begin
            run_stream(320, SIZE_SMALL, 85);
            done += 320;
        end
        if (with_hold) rx_hold_req = 1'b1;
        while (done < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 8);
                run_noise(len);
            end else begin
                len = $urandom_range(10, 60);
                sel = $urandom_range(0, 9);
                size_kind = (sel < 4) ? SIZE_SMALL : (sel < 8) ? SIZE_MEDIUM : SIZE_HUGE;
                run_stream(len, size_kind, 55);
            end
            done += len;
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, zero size, exact and over limit, far target
        drive_beat(tfdb_pkg::OP_QUERY, '0, '0);
        drive_beat(tfdb_pkg::OP_PUSH, '0, '0);
        drive_beat(tfdb_pkg::OP_PUSH, '0, 32'd1);
        drive_beat(tfdb_pkg::OP_QUERY, '0, '0);
        drive_beat(tfdb_pkg::OP_QUERY, '0, '1);
        drive_beat(tfdb_pkg::OP_PUSH, 48'd1000, '1);
        drive_beat(tfdb_pkg::OP_QUERY, 48'd5, '0);
        drive_beat(tfdb_pkg::OP_PUSH, '1, 32'd134217728);
        drive_beat(tfdb_pkg::OP_QUERY, '1, '0);
        drive_beat(tfdb_pkg::OP_PUSH, '1 - 48'd1, 32'd1);
        drive_beat(tfdb_pkg::OP_QUERY, '0, '0);

        // zero limit drops everything
        drain_and_settle();
        write_config('0, '1);
        drive_beat(tfdb_pkg::OP_PUSH, 48'd10, 32'd1);
        drive_beat(tfdb_pkg::OP_QUERY, 48'd20, '0);

        // negative target, early scan stop, repeat frame
        drain_and_settle();
        write_config('1, '1);
        drive_beat(tfdb_pkg::OP_PUSH, '0, 32'd7);
        drive_beat(tfdb_pkg::OP_PUSH, 48'd500, 32'd9);
        drive_beat(tfdb_pkg::OP_QUERY, 48'd1000, '0);
        drive_beat(tfdb_pkg::OP_PUSH, 48'd2000, 32'd1);
        drive_beat(tfdb_pkg::OP_PUSH, 48'd520, 32'd1);
        drive_beat(tfdb_pkg::OP_QUERY, 48'd66065, '0);
        drive_beat(tfdb_pkg::OP_QUERY, 48'd67535, '0);
        drive_beat(tfdb_pkg::OP_QUERY, 48'd67535, '0);

        run_phase(13'd128, 16'd0, 260, 1'b1, 1'b1);
        run_phase(13'd8096, 16'd60000, 260, 1'b0, 1'b0);
        run_phase(13'd1, 16'd250, 260, 1'b1, 1'b0);
        run_phase(tfdb_pkg::MBYTES_W'($urandom_range(128, 8096)),
                  tfdb_pkg::DELAY_W'($urandom_range(0, 60000)), 240, 1'b0, 1'b0);
        run_phase('1, '1, 240, 1'b1, 1'b0);
        run_phase('0, tfdb_pkg::DELAY_W'($urandom_range(0, 60000)), 30, 1'b0, 1'b0);
        run_phase(tfdb_pkg::MBYTES_W'($urandom_range(2, 64)),
                  tfdb_pkg::DELAY_W'($urandom_range(0, 2000)), 240, 1'b1, 1'b0);
        run_phase(13'd128, 16'd1000, 240, 1'b0, 1'b0);

        drain_and_settle();
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("timestamped_frame_delay_buffer_tb passed");
        end else begin
            if (sb.waiting() != 0) begin
                $display("%0t: %0d expected beats never arrived", $time, sb.waiting());
            end
            $display("timestamped_frame_delay_buffer_tb failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tfdb_pkg.sv
hdl/tfdb_ctrl.sv
hdl/tfdb_dp.sv
hdl/timestamped_frame_delay_buffer.sv
sim/timestamped_frame_delay_buffer_tb.sv
